FILE: design/lehmer64_random_generator_macros.svh
// ----------------------------------------------------------------------------
// Lehmer64 random generator assertion macros
// Shared concurrent assertion forms for the generator RTL.
// ----------------------------------------------------------------------------
`ifndef LEHMER64_RANDOM_GENERATOR_MACROS_SVH
`define LEHMER64_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LRG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define LRG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/lrg_pkg.sv
// ----------------------------------------------------------------------------
// Lehmer64 random generator package
// Operation codes, constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lrg_pkg;

    // Multiplier of the generator and the seed scramble value.
    localparam logic [63:0] LEHMER_MULT = 64'hda942042e4dd58b5;
    localparam logic [63:0] SEED_XOR    = 64'd25;

    // Field widths.
    localparam int STATE_W = 128;
    localparam int WORD_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int BOUND_W = 32;
    localparam int SPAN_W  = BOUND_W + 1;

    // One multiplier bit and one dividend bit per cycle.
    localparam int STEPS = WORD_W;
    localparam int CNT_W = $clog2(STEPS);

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_SEED    = 2'd1,
        OP_NEXT    = 2'd2,
        OP_RANGE   = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             seed_apply;
        logic             mul_step;
        logic             div_step;
        logic             last;
        logic             out_load;
        logic [CNT_W-1:0] count;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic range_gt;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/lrg_dp.sv
// ----------------------------------------------------------------------------
// Lehmer64 random generator datapath
// State register, bit-serial multiplier, restoring divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lehmer64_random_generator_macros.svh"

module lrg_dp
    import lrg_pkg::*;
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  cmd_t                  cmd,
    output sts_t                        sts,
    input  wire  logic [1:0]            in_op,
    input  wire  logic [BYTE_W-1:0]     in_seed_byte,
    input  wire  logic [BOUND_W-1:0]    in_range_low,
    input  wire  logic [BOUND_W-1:0]    in_range_high,
    output logic [WORD_W-1:0]           raw_value,
    output logic [BOUND_W-1:0]          bounded_value,
    output logic                        range_error
);

    // Captured item.
    op_t                 op_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [BOUND_W-1:0]  low_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic                lt_reg;
    logic                eq_reg;

    // Generator state and working registers.
    logic [STATE_W-1:0]  state_reg;
    logic [STATE_W-1:0]  state_next;
    logic [STATE_W-1:0]  acc_reg;
    logic [STATE_W-1:0]  acc_next;
    logic [SPAN_W-1:0]   rem_reg;
    logic [SPAN_W-1:0]   rem_next;

    // Result registers.
    logic [WORD_W-1:0]   out_raw_reg;
    logic [BOUND_W-1:0]  out_bounded_reg;
    logic                out_err_reg;

    logic [SPAN_W-1:0]   low_ext;
    logic [SPAN_W-1:0]   high_ext;
    logic [STATE_W-1:0]  seed_ext;
    logic [STATE_W-1:0]  seed_sum;
    logic [WORD_W-1:0]   raw_word;
    logic [SPAN_W:0]     rem_shift;
    logic                rem_ge;
    logic [SPAN_W:0]     rem_diff;
    logic [BOUND_W-1:0]  bounded_calc;

    // Bounds sign-extended to 33 bits for the span.
    assign low_ext  = {in_range_low[BOUND_W-1], in_range_low};
    assign high_ext = {in_range_high[BOUND_W-1], in_range_high};

    // Latch the item and precompute the span and bound relations.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(in_op);
            byte_reg <= in_seed_byte;
            low_reg  <= in_range_low;
            span_reg <= high_ext - low_ext + SPAN_W'(1);
            lt_reg   <= $signed(in_range_high) < $signed(in_range_low);
            eq_reg   <= in_range_high == in_range_low;
        end
    end

    assign sts.op       = op_reg;
    assign sts.range_gt = !lt_reg && !eq_reg;

    // Seed byte sign-extended to the full state and added.
    assign seed_ext = {{(STATE_W-BYTE_W){byte_reg[BYTE_W-1]}}, byte_reg};
    assign seed_sum = state_reg + seed_ext;

    // Shift-add multiplier, multiplier constant consumed from the top bit down.
    assign acc_next = {acc_reg[STATE_W-2:0], 1'b0}
                    + (LEHMER_MULT[~cmd.count] ? state_reg : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
        end
    end

    // State update: restart, seed, or commit of the finished product.
    always_comb
    begin
        state_next = state_reg;
        if (cmd.seed_apply)
        begin
            if (op_reg == OP_RESTART)
            begin
                state_next = STATE_W'(1);
            end
            else
            begin
                state_next = {seed_sum[STATE_W-1:WORD_W], seed_sum[WORD_W-1:0] ^ SEED_XOR};
            end
        end
        else if (cmd.mul_step && cmd.last)
        begin
            state_next = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign raw_word = state_reg[STATE_W-1:WORD_W];

    // Restoring divider: one dividend bit per cycle, remainder only.
    assign rem_shift = {rem_reg, raw_word[~cmd.count]};
    assign rem_ge    = rem_shift >= {1'b0, span_reg};
    assign rem_diff  = rem_shift - {1'b0, span_reg};
    assign rem_next  = rem_ge ? rem_diff[SPAN_W-1:0] : rem_shift[SPAN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step && cmd.last)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
    end

    // Remainder is below 2^32, so the low word alone carries the sum.
    assign bounded_calc = rem_reg[BOUND_W-1:0] + low_reg;

    // Result registers, loaded when the output side is free.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (op_reg == OP_NEXT)
            begin
                out_raw_reg     <= raw_word;
                out_bounded_reg <= '0;
                out_err_reg     <= 1'b0;
            end
            else if (op_reg == OP_RANGE)
            begin
                out_raw_reg     <= raw_word;
                out_err_reg     <= lt_reg;
                out_bounded_reg <= (lt_reg || eq_reg) ? low_reg : bounded_calc;
            end
            else
            begin
                out_raw_reg     <= '0;
                out_bounded_reg <= '0;
                out_err_reg     <= 1'b0;
            end
        end
    end

    assign raw_value     = out_raw_reg;
    assign bounded_value = out_bounded_reg;
    assign range_error   = out_err_reg;

    // A restart leaves the state at one.
    `LRG_ASSERT_NEXT(a_restart_one, clk, rst_n,
        cmd.seed_apply && (op_reg == OP_RESTART), state_reg == STATE_W'(1))
    // The running remainder stays below the span.
    `LRG_ASSERT_IMPLIES(a_rem_below_span, clk, rst_n, cmd.div_step, rem_reg < span_reg)

endmodule

`default_nettype wire

FILE: design/lrg_ctrl.sv
// ----------------------------------------------------------------------------
// Lehmer64 random generator controller
// Sequences capture, seeding, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lehmer64_random_generator_macros.svh"

module lrg_ctrl
    import lrg_pkg::*;
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       s_valid,
    output logic             s_ready,
    input  wire  logic [1:0] in_op,
    output logic             m_valid,
    input  wire  logic       m_ready,
    output cmd_t             cmd,
    input  wire  sts_t       sts
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEED = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              accept;
    logic              out_free;
    logic              last;

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last     = count_reg == CNT_W'(STEPS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op_t'(in_op) == OP_RESTART) || (op_t'(in_op) == OP_SEED))
                    begin
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SEED:
            begin
                state_next = ST_DONE;
            end
            ST_MUL:
            begin
                if (last)
                begin
                    if ((sts.op == OP_RANGE) && sts.range_gt)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Bit counter shared by the multiply and divide passes.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = '0;
        end
        else if ((state_reg == ST_MUL) || (state_reg == ST_DIV))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Output valid: set on a result load, cleared when the transfer completes.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Commands to the datapath.
    assign cmd.capture    = accept;
    assign cmd.seed_apply = state_reg == ST_SEED;
    assign cmd.mul_step   = state_reg == ST_MUL;
    assign cmd.div_step   = state_reg == ST_DIV;
    assign cmd.last       = last;
    assign cmd.out_load   = (state_reg == ST_DONE) && out_free;
    assign cmd.count      = count_reg;

    assign m_valid = m_valid_reg;

    // A result is loaded only into a free output register.
    `LRG_ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.out_load, !m_valid_reg || m_ready)
    // A span above one goes on to the divide pass.
    `LRG_ASSERT_NEXT(a_mul_to_div, clk, rst_n,
        (state_reg == ST_MUL) && last && (sts.op == OP_RANGE) && sts.range_gt,
        state_reg == ST_DIV)
    // The divide pass starts from bit count zero.
    `LRG_ASSERT_NEXT(a_div_count_zero, clk, rst_n,
        (state_reg != ST_DIV) && (state_next == ST_DIV), count_reg == '0)

endmodule

`default_nettype wire

FILE: design/lehmer64_random_generator.sv
// ----------------------------------------------------------------------------
// Lehmer64 random generator
// Lehmer generator with 128-bit state, seeding and bounded output.
// ----------------------------------------------------------------------------
// One item is worked at a time. A restart or seed item passes through the
// seed and done states before its result enters the output register. A next
// item runs the bit-serial multiplier, which consumes one bit of the 64-bit
// constant per cycle. A bounded item with a span above one runs the multiply
// pass followed by a restoring divider that retires one dividend bit
// per cycle. With a ready receiver the result transfers on the following edge.
// A new item is accepted the cycle after its predecessor's result enters the
// output register, even while that result still waits to be taken.
`default_nettype none

module lehmer64_random_generator
    import lrg_pkg::*;
(
    input  wire  logic         clk,
    input  wire  logic         rst_n,
    input  wire  logic         s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: seed_byte[7:0], range_low[39:8], range_high[71:40]
    input  wire  logic [71:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  wire  logic [1:0]   s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire  logic         m_axis_tready,
    // tdata: raw_value[63:0], bounded_value[95:64]
    output logic [95:0]        m_axis_tdata,
    // tuser: range_error[0]
    output logic               m_axis_tuser
);

    cmd_t                cmd;
    sts_t                sts;
    logic [WORD_W-1:0]   raw_value;
    logic [BOUND_W-1:0]  bounded_value;

    // Sequencer.
    lrg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .in_op   (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Arithmetic and state.
    lrg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (s_axis_tuser),
        .in_seed_byte  (s_axis_tdata[7:0]),
        .in_range_low  (s_axis_tdata[39:8]),
        .in_range_high (s_axis_tdata[71:40]),
        .raw_value     (raw_value),
        .bounded_value (bounded_value),
        .range_error   (m_axis_tuser)
    );

    assign m_axis_tdata = {bounded_value, raw_value};

endmodule

`default_nettype wire
